>>> src/gsc_pkg.sv
// Shared types and constants for the Gaussian splat covariance block.
// Used by every module under src; depends on nothing.
package gsc_pkg;

	// Input item fields and packing
	localparam int QW     = 16;
	localparam int SCW    = 24;
	localparam int OPW    = 16;
	localparam int IN_W   = 152;
	localparam int OP_LSB = 136;
	localparam int SC_LSB = 64;

	// Configuration
	localparam int SFW    = 16;
	localparam int THW    = 13;
	localparam int SGW    = 8;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] CFG_SIZE  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_THR   = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_SIGMA = 2'd2;

	// Datapath widths
	localparam int SSW    = 32;   // scaled scale, Q16.16
	localparam int AW     = 13;   // clamped opacity, Q1.12
	localparam int COV_UW = 47;
	localparam int COV_SW = 48;
	localparam int EXW    = 32;
	localparam int RAD_W  = 47;
	localparam int ROOT_W = 24;
	localparam int QUO_W  = 31;
	localparam int DVD_W  = 63;
	localparam int DVS_W  = 33;
	localparam int ROT_N  = 9;
	localparam int SQ_N   = 3;
	localparam int OUT_W  = 400;
	localparam int ST_W   = 2;

	localparam logic [AW-1:0] ALPHA_ONE = 13'd4096;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_LOW_ALPHA = 2'd1;
	localparam logic [ST_W-1:0] ST_ZERO_VOL  = 2'd2;

	typedef struct packed {
		logic [SFW-1:0] size;
		logic [THW-1:0] thr;
		logic [SGW-1:0] sigma;
	} cfg_t;

	// One classified splat between front and back; quat[0] is w
	typedef struct packed {
		logic [3:0][QW-1:0]  quat;
		logic [2:0][SSW-1:0] sc;
		logic                low;
		logic [AW-1:0]       alpha;
	} qent_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [COV_UW-1:0] cov_xx;
		logic [COV_SW-1:0] cov_xy;
		logic [COV_SW-1:0] cov_xz;
		logic [COV_UW-1:0] cov_yy;
		logic [COV_SW-1:0] cov_yz;
		logic [COV_UW-1:0] cov_zz;
		logic [AW-1:0]     alpha;
		logic [EXW-1:0]    extent_x;
		logic [EXW-1:0]    extent_y;
		logic [EXW-1:0]    extent_z;
	} res_t;

endpackage

>>> src/gsc_front.sv
// Front end: input register, opacity classification and scale times size factor.
// Depends on gsc_pkg; feeds gsc_queue.
module gsc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [gsc_pkg::IN_W-1:0] s_tdata,
	input  gsc_pkg::cfg_t            cfg,
	input  logic                     full,
	output logic                     push,
	output gsc_pkg::qent_t           push_ent
);
	import gsc_pkg::*;

	logic            f_vld_q;
	logic [IN_W-1:0] f_data_q;
	logic signed [OPW-1:0] op;
	logic [SCW+SFW-1:0] sc_prod [3];

	assign s_tready = !f_vld_q || !full;
	assign push     = f_vld_q && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_vld_q <= 1'b0;
		end else if (s_tready) begin
			f_vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			f_data_q <= s_tdata;
		end
	end

	always_comb begin
		op = signed'(f_data_q[OP_LSB +: OPW]);
		for (int i = 0; i < 4; i++) begin
			push_ent.quat[i] = f_data_q[QW*i +: QW];
		end
		// round half up into Q16.16
		for (int j = 0; j < 3; j++) begin
			sc_prod[j] = (SCW+SFW)'(f_data_q[SC_LSB + SCW*j +: SCW]) * (SCW+SFW)'(cfg.size)
				+ (SCW+SFW)'(128);
			push_ent.sc[j] = sc_prod[j][SCW+SFW-1 -: SSW];
		end
		push_ent.low = $signed({op[OPW-1], op}) < $signed({4'b0, cfg.thr});
		if (op[OPW-1]) begin
			push_ent.alpha = '0;
		end else if (op > $signed({3'b0, ALPHA_ONE})) begin
			push_ent.alpha = ALPHA_ONE;
		end else begin
			push_ent.alpha = op[AW-1:0];
		end
	end

endmodule

>>> src/gsc_queue.sv
// Short FIFO of classified splats between the front end and the back end.
// Depends on gsc_pkg.
module gsc_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gsc_pkg::qent_t push_ent,
	output logic           full,
	input  logic           pop,
	output gsc_pkg::qent_t pop_ent,
	output logic           empty
);
	import gsc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qent_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign pop_ent = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ent;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("pop from an empty queue");
	a_count_drop: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1) else $error("count did not drop");

endmodule

>>> src/gsc_div.sv
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient bit a stage.
// Depends on gsc_pkg; used by gsc_back for the rotation entries.
module gsc_div (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [gsc_pkg::ROT_N-1:0][gsc_pkg::DVD_W-1:0] dvd,
	input  logic [gsc_pkg::DVS_W-1:0]                  dvs,
	output logic [gsc_pkg::ROT_N-1:0][gsc_pkg::QUO_W-1:0] quo
);
	import gsc_pkg::*;

	// Remainder starts as the top dividend bits, which the caller keeps below dvs.
	logic [DVS_W-1:0]                  dvs_s [QUO_W];
	logic [ROT_N-1:0][DVS_W-1:0]       rem_s [QUO_W];
	logic [ROT_N-1:0][QUO_W-1:0]       lq_s  [QUO_W];
	logic [ROT_N-1:0][DVS_W-1:0]       rem_n [QUO_W];
	logic [ROT_N-1:0][QUO_W-1:0]       lq_n  [QUO_W];
	logic [DVS_W-1:0]                  dvs_n [QUO_W];

	always_comb begin
		logic [DVS_W-1:0] ri;
		logic [QUO_W-1:0] li;
		logic [DVS_W-1:0] di;
		logic [DVS_W:0]   t;
		logic [DVS_W:0]   diff;
		logic             ge;
		for (int i = 0; i < QUO_W; i++) begin
			di = (i == 0) ? dvs : dvs_s[i-1];
			dvs_n[i] = di;
			for (int l = 0; l < ROT_N; l++) begin
				if (i == 0) begin
					ri = {1'b0, dvd[l][DVD_W-1:QUO_W]};
					li = dvd[l][QUO_W-1:0];
				end else begin
					ri = rem_s[i-1][l];
					li = lq_s[i-1][l];
				end
				t    = {ri, li[QUO_W-1]};
				diff = t - {1'b0, di};
				ge   = t >= {1'b0, di};
				rem_n[i][l] = ge ? diff[DVS_W-1:0] : t[DVS_W-1:0];
				// shift dividend bits out at the top, quotient bits in at the bottom
				lq_n[i][l]  = {li[QUO_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_s <= dvs_n;
			rem_s <= rem_n;
			lq_s  <= lq_n;
		end
	end

	assign quo = lq_s[QUO_W-1];

endmodule

>>> src/gsc_isqrt.sv
// Pipelined integer square root, three lanes, one result bit a stage.
// Depends on gsc_pkg; used by gsc_back for the extents.
module gsc_isqrt (
	input  logic                                        clk,
	input  logic                                        en,
	input  logic [gsc_pkg::SQ_N-1:0][gsc_pkg::RAD_W-1:0]  rad,
	output logic [gsc_pkg::SQ_N-1:0][gsc_pkg::ROOT_W-1:0] root
);
	import gsc_pkg::*;

	localparam int RES_W = RAD_W + 1;

	logic [SQ_N-1:0][RAD_W-1:0] v_s [ROOT_W];
	logic [SQ_N-1:0][RES_W-1:0] r_s [ROOT_W];
	logic [SQ_N-1:0][RAD_W-1:0] v_n [ROOT_W];
	logic [SQ_N-1:0][RES_W-1:0] r_n [ROOT_W];

	always_comb begin
		logic [RAD_W-1:0] vi;
		logic [RES_W-1:0] ri;
		logic [RES_W-1:0] bitv;
		logic [RES_W-1:0] sm;
		for (int i = 0; i < ROOT_W; i++) begin
			bitv = RES_W'(1) << (RAD_W - 1 - 2*i);
			for (int l = 0; l < SQ_N; l++) begin
				vi = (i == 0) ? rad[l] : v_s[i-1][l];
				ri = (i == 0) ? '0 : r_s[i-1][l];
				sm = ri + bitv;
				if ({1'b0, vi} >= sm) begin
					v_n[i][l] = vi - sm[RAD_W-1:0];
					r_n[i][l] = (ri >> 1) + bitv;
				end else begin
					v_n[i][l] = vi;
					r_n[i][l] = ri >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s <= v_n;
			r_s <= r_n;
		end
	end

	always_comb begin
		for (int l = 0; l < SQ_N; l++) begin
			root[l] = r_s[ROOT_W-1][l][ROOT_W-1:0];
		end
	end

endmodule

>>> src/gsc_back.sv
// Back end: rotation from quaternion, M = R*S, covariance, saturation, extents.
// Depends on gsc_pkg, gsc_div and gsc_isqrt; drains gsc_queue.
module gsc_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [gsc_pkg::SGW-1:0] sigma,
	input  logic                    empty,
	output logic                    pop,
	input  gsc_pkg::qent_t          pop_ent,
	output logic                    out_vld,
	input  logic                    out_ready,
	output gsc_pkg::res_t           out_res
);
	import gsc_pkg::*;

	localparam int PR_N  = 10;
	localparam int NUM_W = 34;
	localparam int M_W   = 33;
	localparam int PP_W  = 2 * M_W;
	localparam int SUM_W = PP_W + 2;
	localparam logic [QUO_W-1:0] ONE_Q30 = 31'h4000_0000;
	localparam logic signed [SUM_W-1:0] SAT_HI = 68'sh7FFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SAT_LO = -68'sh8000_0000_0000;
	localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

	typedef struct packed {
		logic [2:0][SSW-1:0] sc;
		logic                low;
		logic [AW-1:0]       alpha;
	} side_t;

	typedef struct packed {
		side_t            side;
		logic [ROT_N-1:0] neg;
		logic             nz;
	} dside_t;

	typedef struct packed {
		logic [5:0][COV_SW-1:0] cov;
		logic                   zero;
		logic                   low;
		logic [AW-1:0]          alpha;
	} qside_t;

	logic en;
	logic out_vld_q;
	res_t out_res_q;

	// Stage 1: quaternion products (ww xx yy zz xy wz xz wy yz wx)
	logic                     v_s1;
	side_t                    side_s1;
	logic signed [2*QW-1:0]   pr_s1 [PR_N];
	logic signed [QW-1:0]     qw, qx, qy, qz;

	// Stage 2: norm and numerators, row-major r00..r22
	logic                     v_s2;
	side_t                    side_s2;
	logic [DVS_W-1:0]         n_s2;
	logic signed [NUM_W-1:0]  num_s2 [ROT_N];
	logic signed [NUM_W-1:0]  p34 [PR_N];
	logic signed [NUM_W-1:0]  n_sum;
	logic signed [NUM_W-1:0]  num_c [ROT_N];

	// Stage 3: divider operands
	logic                              v_s3;
	side_t                             side_s3;
	logic [ROT_N-1:0][DVD_W-1:0]       dvd_s3;
	logic [ROT_N-1:0]                  neg_s3;
	logic [DVS_W-1:0]                  dvs_s3;
	logic                              nz_s3;
	logic [NUM_W-1:0]                  mag_c [ROT_N];

	logic [ROT_N-1:0][QUO_W-1:0]       quo;
	logic [QUO_W-1:0]                  dv_vld_q;
	dside_t                            dv_side_q [QUO_W];
	dside_t                            ds;

	// Stage 4: M entries
	logic                     v_s4;
	logic                     low_s4;
	logic [AW-1:0]            alpha_s4;
	logic signed [M_W-1:0]    m_s4 [ROT_N];
	logic [QUO_W-1:0]         rmag_c [ROT_N];
	logic [DVD_W-1:0]         mp_c [ROT_N];
	logic [M_W-1:0]           mm_c [ROT_N];

	// Stage 5: covariance partial products
	logic                     v_s5;
	logic                     low_s5;
	logic [AW-1:0]            alpha_s5;
	logic signed [PP_W-1:0]   pp_s5 [6][3];

	// Stage 6: sums and saturation
	logic                     v_s6;
	qside_t                   qside_s6;
	logic signed [SUM_W-1:0]  sum_c [6];
	logic [5:0][COV_SW-1:0]   cov_c;

	logic [SQ_N-1:0][ROOT_W-1:0] root;
	logic [ROOT_W-1:0]           sq_vld_q;
	qside_t                      sq_side_q [ROOT_W];
	qside_t                      qs;
	logic [EXW:0]                ext_c [SQ_N];
	res_t                        res_c;

	// Whole back end advances together; the output register frees it.
	assign en      = !out_vld_q || out_ready;
	assign pop     = en && !empty;
	assign out_vld = out_vld_q;
	assign out_res = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			dv_vld_q  <= '0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			sq_vld_q  <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s1      <= pop;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			dv_vld_q  <= {dv_vld_q[QUO_W-2:0], v_s3};
			v_s4      <= dv_vld_q[QUO_W-1];
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			sq_vld_q  <= {sq_vld_q[ROOT_W-2:0], v_s6};
			out_vld_q <= sq_vld_q[ROOT_W-1];
		end
	end

	// Stage 1
	always_comb begin
		qw = signed'(pop_ent.quat[0]);
		qx = signed'(pop_ent.quat[1]);
		qy = signed'(pop_ent.quat[2]);
		qz = signed'(pop_ent.quat[3]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.sc    <= pop_ent.sc;
			side_s1.low   <= pop_ent.low;
			side_s1.alpha <= pop_ent.alpha;
			pr_s1[0] <= qw * qw;
			pr_s1[1] <= qx * qx;
			pr_s1[2] <= qy * qy;
			pr_s1[3] <= qz * qz;
			pr_s1[4] <= qx * qy;
			pr_s1[5] <= qw * qz;
			pr_s1[6] <= qx * qz;
			pr_s1[7] <= qw * qy;
			pr_s1[8] <= qy * qz;
			pr_s1[9] <= qw * qx;
		end
	end

	// Stage 2
	always_comb begin
		for (int k = 0; k < PR_N; k++) begin
			p34[k] = NUM_W'(pr_s1[k]);
		end
		n_sum    = p34[0] + p34[1] + p34[2] + p34[3];
		num_c[0] = p34[0] + p34[1] - p34[2] - p34[3];
		num_c[1] = (p34[4] - p34[5]) <<< 1;
		num_c[2] = (p34[6] + p34[7]) <<< 1;
		num_c[3] = (p34[4] + p34[5]) <<< 1;
		num_c[4] = p34[0] - p34[1] + p34[2] - p34[3];
		num_c[5] = (p34[8] - p34[9]) <<< 1;
		num_c[6] = (p34[6] - p34[7]) <<< 1;
		num_c[7] = (p34[8] + p34[9]) <<< 1;
		num_c[8] = p34[0] - p34[1] - p34[2] + p34[3];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			n_s2    <= n_sum[DVS_W-1:0];
			num_s2  <= num_c;
		end
	end

	// Stage 3: dividend = |num| * 2^30 + n/2 gives rounding half away from zero
	always_comb begin
		for (int j = 0; j < ROT_N; j++) begin
			mag_c[j] = num_s2[j][NUM_W-1] ? NUM_W'(-num_s2[j]) : NUM_W'(num_s2[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			nz_s3   <= n_s2 == '0;
			dvs_s3  <= (n_s2 == '0) ? DVS_W'(1) : n_s2;
			for (int j = 0; j < ROT_N; j++) begin
				dvd_s3[j] <= {mag_c[j][DVS_W-1:0], 30'b0} + DVD_W'(n_s2 >> 1);
				neg_s3[j] <= num_s2[j][NUM_W-1];
			end
		end
	end

	gsc_div u_div (
		.clk (clk),
		.en  (en),
		.dvd (dvd_s3),
		.dvs (dvs_s3),
		.quo (quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_q[0] <= '{side: side_s3, neg: neg_s3, nz: nz_s3};
			for (int i = 1; i < QUO_W; i++) begin
				dv_side_q[i] <= dv_side_q[i-1];
			end
		end
	end

	// Stage 4: m = round(r * s), zero quaternion takes the identity
	always_comb begin
		ds = dv_side_q[QUO_W-1];
		for (int j = 0; j < ROT_N; j++) begin
			if (ds.nz) begin
				rmag_c[j] = (j % 4 == 0) ? ONE_Q30 : '0;
			end else begin
				rmag_c[j] = quo[j];
			end
			mp_c[j] = DVD_W'(rmag_c[j]) * DVD_W'(ds.side.sc[j % 3]) + (DVD_W'(1) << 29);
			mm_c[j] = mp_c[j][DVD_W-1:30];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			low_s4   <= ds.side.low;
			alpha_s4 <= ds.side.alpha;
			for (int j = 0; j < ROT_N; j++) begin
				m_s4[j] <= ds.neg[j] ? -signed'(mm_c[j]) : signed'(mm_c[j]);
			end
		end
	end

	// Stage 5
	always_ff @(posedge clk) begin
		if (en) begin
			low_s5   <= low_s4;
			alpha_s5 <= alpha_s4;
			for (int k = 0; k < 6; k++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s5[k][j] <= m_s4[PA[k]*3 + j] * m_s4[PB[k]*3 + j];
				end
			end
		end
	end

	// Stage 6: diagonal sums are never negative
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			sum_c[k] = SUM_W'(pp_s5[k][0]) + SUM_W'(pp_s5[k][1]) + SUM_W'(pp_s5[k][2]);
			if (sum_c[k] > SAT_HI) begin
				cov_c[k] = SAT_HI[COV_SW-1:0];
			end else if (sum_c[k] < SAT_LO) begin
				cov_c[k] = SAT_LO[COV_SW-1:0];
			end else begin
				cov_c[k] = sum_c[k][COV_SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qside_s6.cov   <= cov_c;
			qside_s6.zero  <= (sum_c[0] == '0) && (sum_c[3] == '0) && (sum_c[5] == '0);
			qside_s6.low   <= low_s5;
			qside_s6.alpha <= alpha_s5;
		end
	end

	gsc_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  ({qside_s6.cov[5][RAD_W-1:0], qside_s6.cov[3][RAD_W-1:0],
			qside_s6.cov[0][RAD_W-1:0]}),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side_q[0] <= qside_s6;
			for (int i = 1; i < ROOT_W; i++) begin
				sq_side_q[i] <= sq_side_q[i-1];
			end
		end
	end

	// Output stage: extents and the drop decision
	always_comb begin
		qs = sq_side_q[ROOT_W-1];
		for (int l = 0; l < SQ_N; l++) begin
			ext_c[l] = (EXW+1)'(sigma) * (EXW+1)'(root[l]) + (EXW+1)'(8);
		end
		res_c = '0;
		if (qs.low) begin
			res_c.status = ST_LOW_ALPHA;
		end else if (qs.zero) begin
			res_c.status = ST_ZERO_VOL;
		end else begin
			res_c.status   = ST_OK;
			res_c.cov_xx   = qs.cov[0][COV_UW-1:0];
			res_c.cov_xy   = qs.cov[1];
			res_c.cov_xz   = qs.cov[2];
			res_c.cov_yy   = qs.cov[3][COV_UW-1:0];
			res_c.cov_yz   = qs.cov[4];
			res_c.cov_zz   = qs.cov[5][COV_UW-1:0];
			res_c.alpha    = qs.alpha;
			res_c.extent_x = EXW'(ext_c[0] >> 4);
			res_c.extent_y = EXW'(ext_c[1] >> 4);
			res_c.extent_z = EXW'(ext_c[2] >> 4);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res_q <= res_c;
		end
	end

	a_drop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_res_q.status != ST_OK |->
			out_res_q.cov_xx == '0 && out_res_q.alpha == '0 && out_res_q.extent_x == '0)
		else $error("dropped splat carries data");
	a_ok_has_volume: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_res_q.status == ST_OK |->
			out_res_q.cov_xx != '0 || out_res_q.cov_yy != '0 || out_res_q.cov_zz != '0)
		else $error("accepted splat with zero volume");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dv_vld_q) && $stable(sq_vld_q) && $stable(v_s4))
		else $error("pipeline moved while stalled");

endmodule

>>> src/gaussian_splat_covariance.sv
// Top level of the Gaussian splat covariance block: config registers, front, queue, back.
// Depends on gsc_pkg, gsc_front, gsc_queue, gsc_back.
//
// One splat goes in and one result comes out per clock when both sides keep their
// handshakes up. The 31-stage divider normalizes the rotation entries and the
// 24-stage square root lies behind the extents. The back end moves as one pipeline
// and holds as a whole while the output register waits; the queue between front
// and back (QUEUE_DEPTH entries) keeps the input side taking splats during short
// stalls. Configuration writes take effect at once and belong in idle periods.
// status in m_tuser is 0 for a kept splat, 1 for low opacity and 2 for zero
// volume; dropped splats carry zeros in every data field.
module gaussian_splat_covariance #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z, opacity
	input  logic [gsc_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz, alpha_clamped,
	// extent_x, extent_y, extent_z, zero fill
	output logic [gsc_pkg::OUT_W-1:0]  m_tdata,
	// status
	output logic [gsc_pkg::ST_W-1:0]   m_tuser,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [gsc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [gsc_pkg::CFG_DW-1:0] cfg_data
);
	import gsc_pkg::*;

	localparam int PAD_W = OUT_W - 394;

	cfg_t  cfg_q;
	logic  full;
	logic  empty;
	logic  push;
	logic  pop;
	qent_t push_ent;
	qent_t pop_ent;
	res_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size  <= 16'd256;
			cfg_q.thr   <= 13'd16;
			cfg_q.sigma <= 8'd48;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SIZE: begin
					cfg_q.size <= cfg_data[SFW-1:0];
				end
				CFG_THR: begin
					cfg_q.thr <= cfg_data[THW-1:0];
				end
				CFG_SIGMA: begin
					cfg_q.sigma <= cfg_data[SGW-1:0];
				end
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	gsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg_q),
		.full     (full),
		.push     (push),
		.push_ent (push_ent)
	);

	gsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (full),
		.pop      (pop),
		.pop_ent  (pop_ent),
		.empty    (empty)
	);

	gsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sigma     (cfg_q.sigma),
		.empty     (empty),
		.pop       (pop),
		.pop_ent   (pop_ent),
		.out_vld   (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {PAD_W'(0), res.extent_z, res.extent_y, res.extent_x, res.alpha,
		res.cov_zz, res.cov_yz, res.cov_yy, res.cov_xz, res.cov_xy, res.cov_xx};

endmodule

>>> bench/testbench.sv
// Self-checking bench for gaussian_splat_covariance: random and directed splats,
// random stalls on both sides, expected results from a behavioral model. Uses gsc_pkg.
module testbench;
	import gsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ST_W-1:0] status;
		logic [COV_UW-1:0] cxx, cyy, czz;
		logic [COV_SW-1:0] cxy, cxz, cyz;
		logic [AW-1:0] alpha;
		logic [EXW-1:0] ex, ey, ez;
	} splat_res_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0, cfg_valid = 0;
	logic [IN_W-1:0] s_tdata = '0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic s_tready, m_tvalid, cfg_ready;
	logic [OUT_W-1:0] m_tdata;
	logic [ST_W-1:0] m_tuser;

	gaussian_splat_covariance dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	logic [SFW-1:0] size_reg;
	logic [THW-1:0] thr_reg;
	logic [SGW-1:0] sigma_reg;
	splat_res_t pending_res[$];
	int errors = 0;
	int idle_cycles = 0;
	bit src_idle_en = 1, sink_idle_en = 1;
	bit hold_go = 0, hold_seen = 0;
	int sink_hold = 0;

	function automatic longint unsigned mag(longint a);
		return a < 0 ? -a : a;
	endfunction

	function automatic longint rot_q30(longint num, longint unsigned n);
		longint unsigned q;
		q = ((mag(num) << 30) + n / 2) / n;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint rs_mul(longint r, longint unsigned s);
		longint unsigned p;
		p = (mag(r) * s + (64'd1 << 29)) >> 30;
		return r < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic splat_res_t predict_splat(logic [IN_W-1:0] d);
		splat_res_t o;
		longint w, x, y, z, op, ww, xx, yy, zz;
		longint unsigned n, sc[3];
		longint r[3][3], m[3][3];
		logic signed [127:0] acc;
		logic [COV_SW-1:0] cv[6];
		int pa[6] = '{0, 0, 0, 1, 1, 2};
		int pb[6] = '{0, 1, 2, 1, 2, 2};
		bit all_zero = 1;
		o = '{default: '0};
		w = $signed(d[15:0]); x = $signed(d[31:16]);
		y = $signed(d[47:32]); z = $signed(d[63:48]);
		op = $signed(d[OP_LSB +: OPW]);
		if (op < longint'(thr_reg)) begin
			o.status = ST_LOW_ALPHA;
			return o;
		end
		ww = w * w; xx = x * x; yy = y * y; zz = z * z;
		n = ww + xx + yy + zz;
		if (n == 0) begin
			foreach (r[i, j]) r[i][j] = (i == j) ? (64'd1 << 30) : 0;
		end else begin
			r[0][0] = rot_q30(ww + xx - yy - zz, n);
			r[1][0] = rot_q30(2 * (x * y + w * z), n);
			r[2][0] = rot_q30(2 * (x * z - w * y), n);
			r[0][1] = rot_q30(2 * (x * y - w * z), n);
			r[1][1] = rot_q30(ww - xx + yy - zz, n);
			r[2][1] = rot_q30(2 * (y * z + w * x), n);
			r[0][2] = rot_q30(2 * (x * z + w * y), n);
			r[1][2] = rot_q30(2 * (y * z - w * x), n);
			r[2][2] = rot_q30(ww - xx - yy + zz, n);
		end
		for (int j = 0; j < 3; j++)
			sc[j] = (longint'(d[SC_LSB + 24 * j +: SCW]) * size_reg + 128) >> 8;
		foreach (m[i, j]) m[i][j] = rs_mul(r[i][j], sc[j]);
		for (int k = 0; k < 6; k++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += 128'(signed'(m[pa[k]][j])) * 128'(signed'(m[pb[k]][j]));
			if (pa[k] == pb[k]) begin
				if (acc != 0) all_zero = 0;
				cv[k] = (acc > 128'sh7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : acc[47:0];
			end else if (acc > 128'sh7FFF_FFFF_FFFF)
				cv[k] = 48'h7FFF_FFFF_FFFF;
			else if (acc < -128'sh8000_0000_0000)
				cv[k] = 48'h8000_0000_0000;
			else
				cv[k] = acc[47:0];
		end
		if (all_zero) begin
			o.status = ST_ZERO_VOL;
			return o;
		end
		o.status = ST_OK;
		o.cxx = cv[0][COV_UW-1:0]; o.cxy = cv[1]; o.cxz = cv[2];
		o.cyy = cv[3][COV_UW-1:0]; o.cyz = cv[4]; o.czz = cv[5][COV_UW-1:0];
		o.alpha = op > 4096 ? ALPHA_ONE : (op < 0 ? '0 : op[AW-1:0]);
		o.ex = EXW'((sigma_reg * int_sqrt(cv[0]) + 8) >> 4);
		o.ey = EXW'((sigma_reg * int_sqrt(cv[3]) + 8) >> 4);
		o.ez = EXW'((sigma_reg * int_sqrt(cv[5]) + 8) >> 4);
		return o;
	endfunction

	// sink side: random stalls, forced long hold, result check
	always @(posedge clk) begin
		splat_res_t e;
		res_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status   = m_tuser;
				got.cov_xx   = m_tdata[46:0];
				got.cov_xy   = m_tdata[94:47];
				got.cov_xz   = m_tdata[142:95];
				got.cov_yy   = m_tdata[189:143];
				got.cov_yz   = m_tdata[237:190];
				got.cov_zz   = m_tdata[284:238];
				got.alpha    = m_tdata[297:285];
				got.extent_x = m_tdata[329:298];
				got.extent_y = m_tdata[361:330];
				got.extent_z = m_tdata[393:362];
				if (pending_res.size() == 0) begin
					$display("%0t: unexpected result status=%0d", $time, m_tuser);
					errors++;
				end else begin
					e = pending_res.pop_front();
					if (got.status !== e.status || got.cov_xx !== e.cxx ||
					    got.cov_xy !== e.cxy || got.cov_xz !== e.cxz ||
					    got.cov_yy !== e.cyy || got.cov_yz !== e.cyz ||
					    got.cov_zz !== e.czz || got.alpha !== e.alpha ||
					    got.extent_x !== e.ex || got.extent_y !== e.ey ||
					    got.extent_z !== e.ez) begin
						$display("%0t: mismatch expected st=%0d cov=%h %h %h %h %h %h a=%h ext=%h %h %h",
							$time, e.status, e.cxx, e.cxy, e.cxz, e.cyy, e.cyz, e.czz,
							e.alpha, e.ex, e.ey, e.ez);
						$display("%0t: mismatch actual   st=%0d cov=%h %h %h %h %h %h a=%h ext=%h %h %h",
							$time, got.status, got.cov_xx, got.cov_xy, got.cov_xz, got.cov_yy,
							got.cov_yz, got.cov_zz, got.alpha, got.extent_x, got.extent_y,
							got.extent_z);
						errors++;
					end
				end
			end
			if (hold_go && !hold_seen) begin
				hold_seen <= 1;
				sink_hold <= 200;
				m_tready <= 0;
			end else if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				m_tready <= 0;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				sink_hold <= $urandom_range(1, 13);
				m_tready <= 0;
			end else
				m_tready <= 1;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_splat(logic [IN_W-1:0] d);
		if (src_idle_en && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_res = {pending_res, predict_splat(d)};
	endtask

	task automatic drain_results();
		s_tvalid <= 0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			CFG_SIZE: size_reg = val;
			CFG_THR: thr_reg = val[THW-1:0];
			CFG_SIGMA: sigma_reg = val[SGW-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [IN_W-1:0] pack_splat(logic [3:0][15:0] q,
			logic [2:0][23:0] s, logic [15:0] op);
		return {op, s, q};
	endfunction

	function automatic logic [IN_W-1:0] rand_splat();
		logic [3:0][15:0] q;
		logic [2:0][23:0] s;
		logic [15:0] op;
		foreach (q[i]) q[i] = 16'($urandom);
		if ($urandom_range(0, 9) == 0) q = '0;
		foreach (s[i])
			case ($urandom_range(0, 3))
				0: s[i] = 24'($urandom);
				1: s[i] = 24'($urandom_range(0, 1 << 18));
				2: s[i] = 24'($urandom_range(0, 255));
				default: s[i] = 24'($urandom_range(1 << 14, 1 << 17));
			endcase
		op = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4200));
		return pack_splat(q, s, op);
	endfunction

	task automatic test_directed();
		logic [2:0][23:0] one = {3{24'h010000}};
		send_splat(pack_splat('0, one, 16'h1000));
		send_splat(pack_splat({4{16'h7FFF}}, {3{24'hFFFFFF}}, 16'h7FFF));
		send_splat(pack_splat({4{16'h8000}}, {3{24'hFFFFFF}}, 16'h8000));
		send_splat(pack_splat({16'h0, 16'h0, 16'h0, 16'h4000}, one, 16'd15));
		send_splat(pack_splat({16'h0, 16'h0, 16'h0, 16'h4000}, one, 16'd16));
		send_splat(pack_splat({16'h0, 16'h4000, 16'h0, 16'h0}, '0, 16'h0800));
		send_splat(pack_splat({16'h2000, 16'hE000, 16'h2000, 16'h2000}, one, 16'd4097));
		send_splat(pack_splat({16'h0, 16'h0, 16'h4000, 16'h0}, {24'd1, 24'd0, 24'hFFFFFF},
			16'd4096));
		send_splat(pack_splat({16'd1, 16'd0, 16'd0, 16'd0}, {24'd2, 24'd3, 24'd1}, 16'hFFFF));
		send_splat(pack_splat({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
			{24'h555555, 24'hAAAAAA, 24'h123456}, 16'h5555));
		drain_results();
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_SIZE, 16'hFFFF);
		write_reg(CFG_THR, 16'd0);
		write_reg(CFG_SIGMA, 16'h00FF);
		repeat (8) send_splat(rand_splat());
		send_splat(pack_splat('0, {3{24'hFFFFFF}}, 16'h0));
		drain_results();
		write_reg(CFG_SIZE, 16'd0);
		write_reg(CFG_THR, 16'd4097);
		write_reg(CFG_SIGMA, 16'd0);
		repeat (6) send_splat(rand_splat());
		drain_results();
		write_reg(CFG_THR, 16'd4096);
		write_reg(CFG_SIZE, 16'd1);
		repeat (6) send_splat(rand_splat());
		drain_results();
		write_reg(CFG_SIZE, 16'd256);
		write_reg(CFG_THR, 16'd16);
		write_reg(CFG_SIGMA, 16'd48);
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_SIZE, CFG_DW'($urandom));
			write_reg(CFG_THR, CFG_DW'($urandom_range(0, 600)));
			write_reg(CFG_SIGMA, CFG_DW'($urandom));
			repeat (250) send_splat(rand_splat());
			drain_results();
		end
	endtask

	// the pipeline holds about 70 splats; offer more than that during the hold
	task automatic test_backpressure();
		hold_go = 1;
		src_idle_en = 0;
		repeat (150) send_splat(rand_splat());
		drain_results();
	endtask

	task automatic test_no_idle();
		src_idle_en = 0;
		sink_idle_en = 0;
		repeat (170) send_splat(rand_splat());
		drain_results();
	endtask

	initial begin
		size_reg = 256;
		thr_reg = 16;
		sigma_reg = 48;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random();
		test_backpressure();
		test_no_idle();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
